// File: hdl/sssp_pkg.sv
`default_nettype none
package sssp_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxEdges = 256;
	localparam int VIdxBits = 6;
	localparam int EIdxBits = 8;
	localparam int ECntBits = 9;
	localparam int WeightBits = 20;
	localparam int DistBits = 26;
	localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

	localparam logic [1:0] CmdAdd = 2'd0;
	localparam logic [1:0] CmdRun = 2'd1;
	localparam logic [1:0] CmdClear = 2'd2;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StFull = 2'd1;
	localparam logic [1:0] StRange = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] vertex_a;
		logic [5:0] vertex_b;
		logic [19:0] edge_weight;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] vertex_index;
		logic [25:0] distance;
		logic reachable;
		logic last;
	} out_item_t;
endpackage
`default_nettype wire

// File: hdl/single_source_shortest_path_core.sv
// Channel   Direction  Handshake         Payload
// in        input      in_valid/stall    sssp_pkg::in_item_t
// out       output     out_valid/stall   sssp_pkg::out_item_t
// cfg       input      cfg_we            vertex_count (7 bits)
//
// Add and clear: the result sits in the output register the cycle after the item.
// Run: per settled vertex, a min search over the n vertices, one pick state, one scan
// state and a relax pass over the stored edges; each edge that reaches an
// unsettled neighbor adds a LOOK, WAIT and SCAN pass. A final search ends the loop.
// Then n results, each through a LOAD and an EMIT state, EMIT waiting while out_stall holds.
// Reset clears the edge count, marks and control; memories stay unset.
// in_stall is high whenever the sequencer is not idle or a result waits.
`default_nettype none
module single_source_shortest_path_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire sssp_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output sssp_pkg::out_item_t       out_item,
	input  wire logic                 cfg_we,
	input  wire logic [6:0]           cfg_data
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_FIND = 9'b000000010,
		S_PICK = 9'b000000100,
		S_SCAN = 9'b000001000,
		S_RELX = 9'b000010000,
		S_LOOK = 9'b000100000,
		S_WAIT = 9'b001000000,
		S_LOAD = 9'b010000000,
		S_EMIT = 9'b100000000
	} state_t;

	state_t state_q;
	logic [6:0] vcount_q;
	logic [6:0] n_q;
	logic [sssp_pkg::ECntBits-1:0] etotal_q;
	logic [sssp_pkg::MaxVertices-1:0] finite_q, done_q;
	logic [sssp_pkg::VIdxBits-1:0] best_q, vi_q;
	logic found_q;
	logic [sssp_pkg::DistBits-1:0] bd_q;
	logic [sssp_pkg::ECntBits-1:0] ei_q;
	logic rd_v_q;
	logic [sssp_pkg::VIdxBits-1:0] ra_q, rb_q;
	logic [sssp_pkg::WeightBits-1:0] rw_q;
	logic [sssp_pkg::DistBits-1:0] cand_q;
	logic [sssp_pkg::VIdxBits-1:0] to_q;
	logic [sssp_pkg::DistBits-1:0] dist_q;
	logic fv_s1;
	logic [sssp_pkg::VIdxBits-1:0] fi_s1;

	logic [sssp_pkg::VIdxBits-1:0] mem_a [sssp_pkg::MaxEdges];
	logic [sssp_pkg::VIdxBits-1:0] mem_b [sssp_pkg::MaxEdges];
	logic [sssp_pkg::WeightBits-1:0] mem_w [sssp_pkg::MaxEdges];
	logic [sssp_pkg::DistBits-1:0] dist_mem [sssp_pkg::MaxVertices];

	logic out_valid_q;
	sssp_pkg::out_item_t out_q;

	logic [6:0] n_live;
	logic accept, out_free;
	logic add_ok;
	logic run_go, find_go, find_upd, relax_hit, relax_take;
	logic out_load, emit_last;
	sssp_pkg::out_item_t out_next;

	assign n_live = (vcount_q == 7'd0) ? 7'd1 :
		(vcount_q > 7'd64) ? 7'd64 : vcount_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign add_ok = ({1'b0, in_item.vertex_a} < n_live) &&
		({1'b0, in_item.vertex_b} < n_live);
	assign run_go = accept && in_item.command == sssp_pkg::CmdRun &&
		({1'b0, in_item.vertex_a} < n_live);
	assign emit_last = ({1'b0, vi_q} == n_q - 7'd1);

	// Edge table: one write, one registered read.
	always_ff @(posedge clk) begin
		if (accept && in_item.command == sssp_pkg::CmdAdd && add_ok &&
				etotal_q < 9'(sssp_pkg::MaxEdges)) begin
			mem_a[etotal_q[sssp_pkg::EIdxBits-1:0]] <= in_item.vertex_a;
			mem_b[etotal_q[sssp_pkg::EIdxBits-1:0]] <= in_item.vertex_b;
			mem_w[etotal_q[sssp_pkg::EIdxBits-1:0]] <= in_item.edge_weight;
		end
		ra_q <= mem_a[ei_q[sssp_pkg::EIdxBits-1:0]];
		rb_q <= mem_b[ei_q[sssp_pkg::EIdxBits-1:0]];
		rw_q <= mem_w[ei_q[sssp_pkg::EIdxBits-1:0]];
	end

	// Tentative distance store: start write or relax write, registered read at vi_q.
	always_ff @(posedge clk) begin
		if (run_go)
			dist_mem[in_item.vertex_a] <= '0;
		else if (relax_take)
			dist_mem[to_q] <= cand_q;
		dist_q <= dist_mem[vi_q];
	end

	// Relax pipeline: edge read stage then candidate stage.
	logic hit_a, hit_b;
	logic [sssp_pkg::VIdxBits-1:0] to_c;
	logic [sssp_pkg::DistBits:0] sum_c;
	assign hit_a = (ra_q == best_q);
	assign hit_b = (rb_q == best_q);
	assign to_c = hit_a ? rb_q : ra_q;
	assign sum_c = {1'b0, bd_q} + 27'(rw_q);
	assign relax_hit = rd_v_q && {1'b0, ra_q} < n_q && {1'b0, rb_q} < n_q &&
		(hit_a || hit_b) && !done_q[to_c];
	assign relax_take = (state_q == S_WAIT) && (!finite_q[to_q] || cand_q < dist_q);
	// Restart the search on a run or once the edge scan runs dry.
	assign find_go = run_go || (state_q == S_RELX && !rd_v_q);
	// Search compare works on the address from the previous cycle, held in fi_s1.
	assign find_upd = fv_s1 && finite_q[fi_s1] && !done_q[fi_s1] &&
		(!found_q || dist_q < bd_q);
	assign out_load = (accept && (in_item.command == sssp_pkg::CmdAdd ||
		in_item.command == sssp_pkg::CmdClear ||
		(in_item.command == sssp_pkg::CmdRun && !run_go))) ||
		(state_q == S_EMIT && out_free);

	always_comb begin
		out_next = '0;
		out_next.last = 1'b1;
		if (state_q == S_EMIT) begin
			out_next.status = sssp_pkg::StOk;
			out_next.vertex_index = vi_q;
			out_next.reachable = finite_q[vi_q];
			out_next.distance = finite_q[vi_q] ? dist_q : '0;
			out_next.last = emit_last;
		end else begin
			case (in_item.command)
				sssp_pkg::CmdAdd: begin
					if (!add_ok) out_next.status = sssp_pkg::StRange;
					else if (etotal_q >= 9'(sssp_pkg::MaxEdges))
						out_next.status = sssp_pkg::StFull;
				end
				sssp_pkg::CmdRun: out_next.status = sssp_pkg::StRange;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcount_q <= 7'd64;
			etotal_q <= '0;
			finite_q <= '0;
			done_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			rd_v_q <= 1'b0;
			found_q <= 1'b0;
			ei_q <= '0;
			vi_q <= '0;
			best_q <= '0;
			bd_q <= '0;
			to_q <= '0;
			cand_q <= '0;
			fv_s1 <= 1'b0;
			fi_s1 <= '0;
			n_q <= 7'd1;
		end else begin
			if (cfg_we) vcount_q <= cfg_data;
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q <= out_next;
			end else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (accept && in_item.command == sssp_pkg::CmdAdd && add_ok &&
					etotal_q < 9'(sssp_pkg::MaxEdges))
				etotal_q <= etotal_q + 9'd1;
			else if (accept && in_item.command == sssp_pkg::CmdClear)
				etotal_q <= '0;

			if (run_go) finite_q <= 64'd1 << in_item.vertex_a;
			else if (relax_take) finite_q[to_q] <= 1'b1;

			if (run_go) done_q <= '0;
			else if (state_q == S_SCAN && found_q) done_q[best_q] <= 1'b1;

			fv_s1 <= (state_q == S_FIND);
			fi_s1 <= vi_q;
			if (find_go) found_q <= 1'b0;
			else if (find_upd) found_q <= 1'b1;
			if (find_upd) begin
				best_q <= fi_s1;
				bd_q <= dist_q;
			end

			unique case (state_q)
				S_IDLE: begin
					if (run_go) begin
						n_q <= n_live;
						vi_q <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					// Issue one vertex per cycle to the shared compare.
					if ({1'b0, vi_q} == n_q - 7'd1) state_q <= S_PICK;
					else vi_q <= vi_q + 6'd1;
				end
				S_PICK: begin
					// Drain the last compare.
					ei_q <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!found_q) begin
						vi_q <= '0;
						state_q <= S_LOAD;
					end else begin
						rd_v_q <= (ei_q < etotal_q);
						ei_q <= ei_q + 9'd1;
						state_q <= S_RELX;
					end
				end
				S_RELX: begin
					// Edge data for ei_q-1 is in ra_q/rb_q/rw_q.
					if (relax_hit) begin
						// Hold ei_q so the scan resumes at the next edge.
						to_q <= to_c;
						vi_q <= to_c;
						cand_q <= sum_c[sssp_pkg::DistBits] ?
							sssp_pkg::DistMax : sum_c[sssp_pkg::DistBits-1:0];
						state_q <= S_LOOK;
					end else begin
						rd_v_q <= (ei_q < etotal_q);
						ei_q <= ei_q + 9'd1;
						if (!rd_v_q) begin
							vi_q <= '0;
							state_q <= S_FIND;
						end
					end
				end
				S_LOOK: state_q <= S_WAIT;
				S_WAIT: begin
					// Compare candidate against stored distance, then resume.
					state_q <= S_SCAN;
				end
				S_LOAD: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (emit_last) state_q <= S_IDLE;
						else begin
							vi_q <= vi_q + 6'd1;
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(etotal_q <= 9'(sssp_pkg::MaxEdges)))
		else $error("edge count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(out_q))
		else $error("held result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		((done_q & ~finite_q) == '0))
		else $error("settled vertex without distance");
endmodule
`default_nettype wire

// File: tb/sv/single_source_shortest_path_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none

// Predicted distance results of the shortest-path core, checked in arrival order.
class path_scoreboard;
	sssp_pkg::out_item_t pending[$];
	logic [5:0] edge_a[sssp_pkg::MaxEdges];
	logic [5:0] edge_b[sssp_pkg::MaxEdges];
	logic [19:0] edge_w[sssp_pkg::MaxEdges];
	int edge_count;
	logic [6:0] vcount;
	int mismatches;

	function new();
		edge_count = 0;
		vcount = 7'd64;
		mismatches = 0;
	endfunction

	function int live_vertices();
		int n;
		n = int'(vcount);
		if (n < 1) n = 1;
		if (n > sssp_pkg::MaxVertices) n = sssp_pkg::MaxVertices;
		return n;
	endfunction

	function void push(logic [1:0] st, logic [5:0] vi, logic [25:0] d, logic r, logic l);
		sssp_pkg::out_item_t o;
		o.status = st;
		o.vertex_index = vi;
		o.distance = d;
		o.reachable = r;
		o.last = l;
		pending.insert(pending.size(), o);
	endfunction

	function void solve_paths(int start, int n);
		logic [25:0] dist_v[64];
		bit fin[64];
		bit done[64];
		int best;
		logic [25:0] bd;
		longint cand;
		int a;
		int b;
		int to;
		for (int i = 0; i < 64; i++) begin
			fin[i] = 0;
			done[i] = 0;
			dist_v[i] = '0;
		end
		fin[start] = 1;
		forever begin
			best = -1;
			bd = '0;
			for (int i = 0; i < n; i++)
				if (fin[i] && !done[i] && (best < 0 || dist_v[i] < bd)) begin
					best = i;
					bd = dist_v[i];
				end
			if (best < 0) break;
			done[best] = 1;
			for (int e = 0; e < edge_count; e++) begin
				a = int'(edge_a[e]);
				b = int'(edge_b[e]);
				if (a >= n || b >= n) continue;
				for (int side = 0; side < 2; side++) begin
					to = -1;
					if (side == 0 && a == best) to = b;
					if (side == 1 && b == best) to = a;
					if (to < 0 || done[to]) continue;
					cand = longint'(bd) + longint'(edge_w[e]);
					if (cand > longint'(sssp_pkg::DistMax)) cand = longint'(sssp_pkg::DistMax);
					if (!fin[to] || cand < longint'(dist_v[to])) begin
						dist_v[to] = cand[25:0];
						fin[to] = 1;
					end
				end
			end
		end
		for (int i = 0; i < n; i++)
			push(sssp_pkg::StOk, i[5:0], fin[i] ? dist_v[i] : 26'd0, fin[i], i + 1 == n);
	endfunction

	function void note_input(sssp_pkg::in_item_t it);
		int n;
		n = live_vertices();
		case (it.command)
			sssp_pkg::CmdAdd: begin
				if (int'(it.vertex_a) >= n || int'(it.vertex_b) >= n)
					push(sssp_pkg::StRange, 6'd0, 26'd0, 1'b0, 1'b1);
				else if (edge_count >= sssp_pkg::MaxEdges)
					push(sssp_pkg::StFull, 6'd0, 26'd0, 1'b0, 1'b1);
				else begin
					edge_a[edge_count] = it.vertex_a;
					edge_b[edge_count] = it.vertex_b;
					edge_w[edge_count] = it.edge_weight;
					edge_count++;
					push(sssp_pkg::StOk, 6'd0, 26'd0, 1'b0, 1'b1);
				end
			end
			sssp_pkg::CmdClear: begin
				edge_count = 0;
				push(sssp_pkg::StOk, 6'd0, 26'd0, 1'b0, 1'b1);
			end
			sssp_pkg::CmdRun: begin
				if (int'(it.vertex_a) >= n) push(sssp_pkg::StRange, 6'd0, 26'd0, 1'b0, 1'b1);
				else solve_paths(int'(it.vertex_a), n);
			end
			default: ;
		endcase
	endfunction

	task report(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	task check_result(sssp_pkg::out_item_t got);
		sssp_pkg::out_item_t want;
		if (pending.size() == 0) begin
			report("unexpected result, vertex", int'(got.vertex_index), -1);
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status)
			report("status", int'(got.status), int'(want.status));
		if (got.vertex_index !== want.vertex_index)
			report("vertex_index", int'(got.vertex_index), int'(want.vertex_index));
		if (got.distance !== want.distance)
			report("distance", int'(got.distance), int'(want.distance));
		if (got.reachable !== want.reachable)
			report("reachable", int'(got.reachable), int'(want.reachable));
		if (got.last !== want.last) report("last", int'(got.last), int'(want.last));
	endtask
endclass

module single_source_shortest_path_core_tb;
	localparam longint CycleLimit = 64'd40_000_000;
	localparam logic [1:0] CmdSpare = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sssp_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sssp_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_data = 7'd64;

	path_scoreboard board;
	longint cycles = 0;
	bit quiet = 1'b0;	// no idling in the closing stretch

	single_source_shortest_path_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial board = new();

	// Abort the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: check every accepted result; stall in random bursts.
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(out_item);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// Offer one item and hold it until accepted, then note it and drop valid.
	task automatic send_item(input sssp_pkg::in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		board.note_input(it);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_fields(logic [1:0] c, logic [5:0] a, logic [5:0] b, logic [19:0] w);
		sssp_pkg::in_item_t it;
		it.command = c;
		it.vertex_a = a;
		it.vertex_b = b;
		it.edge_weight = w;
		send_item(it);
	endtask

	// Drain all expectations, let the core settle, then write the register.
	task automatic set_vertex_count(logic [6:0] value);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.vcount = value;
	endtask

	// Random edge within n vertices, mostly small weights, some huge.
	task automatic random_edge(int n);
		logic [19:0] w;
		w = ($urandom_range(0, 7) == 0) ? 20'(20'hFFFFF - $urandom_range(0, 3))
			: 20'($urandom_range(0, 2000));
		if ($urandom_range(0, 9) == 0) w = 20'($urandom);
		send_fields(sssp_pkg::CmdAdd, 6'($urandom_range(0, n - 1)),
			6'($urandom_range(0, n - 1)), w);
	endtask

	task automatic random_phase(int n, int items);
		int pick;
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) random_edge(n);
			else if (pick < 80)
				send_fields(sssp_pkg::CmdRun, 6'($urandom_range(0, n - 1)), 6'($urandom),
					20'($urandom));
			else if (pick < 84)
				send_fields(sssp_pkg::CmdClear, 6'($urandom), 6'($urandom), 20'($urandom));
			else if (pick < 87)
				send_fields(CmdSpare, 6'($urandom), 6'($urandom), 20'($urandom));
			else if (pick < 93)
				send_fields(sssp_pkg::CmdAdd, 6'($urandom), 6'($urandom), 20'($urandom));
			else
				send_fields(sssp_pkg::CmdRun, 6'($urandom), 6'($urandom), 20'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every command, self loop, unused code, range errors.
		set_vertex_count(7'd64);
		send_fields(sssp_pkg::CmdAdd, 6'd0, 6'd63, 20'hFFFFF);
		send_fields(sssp_pkg::CmdAdd, 6'd63, 6'd62, 20'hFFFFF);
		send_fields(sssp_pkg::CmdAdd, 6'd5, 6'd5, 20'd7);
		send_fields(sssp_pkg::CmdAdd, 6'd1, 6'd2, 20'd0);
		send_fields(sssp_pkg::CmdAdd, 6'd0, 6'd1, 20'd3);
		send_fields(sssp_pkg::CmdAdd, 6'd0, 6'd2, 20'd3);
		send_fields(sssp_pkg::CmdRun, 6'd0, 6'h3F, 20'hFFFFF);
		send_fields(sssp_pkg::CmdRun, 6'd63, 6'd0, 20'd0);
		send_fields(CmdSpare, 6'h3F, 6'h3F, 20'hFFFFF);
		set_vertex_count(7'd0);	// clamps to one vertex
		send_fields(sssp_pkg::CmdAdd, 6'd1, 6'd0, 20'd1);
		send_fields(sssp_pkg::CmdAdd, 6'd0, 6'd0, 20'd9);
		send_fields(sssp_pkg::CmdRun, 6'd0, 6'd0, 20'd0);
		send_fields(sssp_pkg::CmdRun, 6'd1, 6'd0, 20'd0);
		set_vertex_count(7'd127);	// clamps to the maximum
		send_fields(sssp_pkg::CmdRun, 6'd62, 6'd0, 20'd0);
		set_vertex_count(7'd3);	// stored edges beyond the count are skipped
		send_fields(sssp_pkg::CmdRun, 6'd2, 6'd0, 20'd0);
		send_fields(sssp_pkg::CmdClear, 6'd0, 6'd0, 20'd0);
		send_fields(sssp_pkg::CmdRun, 6'd0, 6'd0, 20'd0);

		// Overflow: maximal-weight edges fill the edge table, then one more add is refused.
		set_vertex_count(7'd64);
		for (int v = 0; v < 63; v++)
			send_fields(sssp_pkg::CmdAdd, 6'(v), 6'(v + 1), 20'hFFFFF);
		for (int v = 0; v < 193; v++)
			send_fields(sssp_pkg::CmdAdd, 6'd0, 6'd63, 20'hFFFFF);
		send_fields(sssp_pkg::CmdAdd, 6'd1, 6'd2, 20'd1);	// table full
		send_fields(sssp_pkg::CmdRun, 6'd0, 6'd0, 20'd0);
		send_fields(sssp_pkg::CmdClear, 6'd0, 6'd0, 20'd0);

		// Random phases over several vertex counts.
		set_vertex_count(7'd8);
		random_phase(8, 35);
		set_vertex_count(7'd2);
		random_phase(2, 15);
		set_vertex_count(7'd16);
		send_fields(sssp_pkg::CmdClear, 6'd0, 6'd0, 20'd0);
		random_phase(16, 30);
		set_vertex_count(7'd5);	// lower the count with edges still stored
		random_phase(5, 20);
		set_vertex_count(7'd64);
		send_fields(sssp_pkg::CmdClear, 6'd0, 6'd0, 20'd0);
		random_phase(64, 15);
		quiet = 1'b1;
		set_vertex_count(7'd12);
		random_phase(12, 15);

		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire

// File: sim.f
hdl/sssp_pkg.sv
hdl/single_source_shortest_path_core.sv
tb/sv/single_source_shortest_path_core_tb.sv
